@@ rtl/core/vfc_pkg.sv @@
// ---------------------------------------------------------------------------
// vfc_pkg
// Shared types, constants and face tables of the culled voxel face mesher.
// ---------------------------------------------------------------------------
package vfc_pkg;

	localparam int unsigned CHUNK_WIDTH_DEF  = 16;
	localparam int unsigned CHUNK_HEIGHT_DEF = 128;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_MESH  = 1'b1;

	localparam logic [2:0] CORNER_LAST = 3'd5;

	typedef enum logic [2:0] {
		FACE_TOP,
		FACE_BOTTOM,
		FACE_LEFT,
		FACE_RIGHT,
		FACE_FRONT,
		FACE_BACK
	} face_t;

	typedef enum logic [2:0] {
		RD_OWN,
		RD_UP,
		RD_DOWN,
		RD_LEFT,
		RD_RIGHT
	} rd_sel_t;

	typedef struct packed {
		logic       opcode;
		logic [3:0] pos_x;
		logic [6:0] pos_y;
		logic [3:0] pos_z;
		logic [3:0] cube_type;
		logic       occupied_value;
		logic       neighbor_left_solid;
		logic       neighbor_right_solid;
		logic       neighbor_front_solid;
		logic       neighbor_back_solid;
	} in_item_t;

	typedef struct packed {
		logic [23:0] vertex_word;
		logic        last_vertex;
	} out_item_t;

	typedef struct packed {
		logic    capture;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    mem_wr;
		logic    clr_en;
		logic    emit;
		face_t   face;
		logic [2:0] corner;
		logic    last;
	} dp_cmd_t;

	typedef struct packed {
		logic       opcode;
		logic [5:0] show;
		logic       out_stall;
		logic       clr_done;
	} dp_stat_t;

	// corner offsets {dx, dy, dz}, two triangles per face
	localparam logic [2:0] CORNER_TAB [6][6] = '{
		'{3'b010, 3'b110, 3'b111, 3'b111, 3'b010, 3'b011},
		'{3'b000, 3'b100, 3'b101, 3'b101, 3'b000, 3'b001},
		'{3'b011, 3'b010, 3'b000, 3'b000, 3'b011, 3'b001},
		'{3'b111, 3'b110, 3'b100, 3'b100, 3'b111, 3'b101},
		'{3'b111, 3'b101, 3'b001, 3'b001, 3'b111, 3'b011},
		'{3'b110, 3'b100, 3'b000, 3'b000, 3'b110, 3'b010}
	};

	localparam logic [2:0] NORMAL_TAB [6] = '{3'd2, 3'd6, 3'd7, 3'd1, 3'd4, 3'd4};

	function automatic logic [2:0] corner_offset(face_t face, logic [2:0] corner);
		return CORNER_TAB[face][corner];
	endfunction

	function automatic logic [2:0] normal_code(face_t face);
		return NORMAL_TAB[face];
	endfunction

endpackage

@@ rtl/core/vfc_stream_if.sv @@
// ---------------------------------------------------------------------------
// vfc_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
interface vfc_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/vfc_datapath.sv @@
// ---------------------------------------------------------------------------
// vfc_datapath
// Occupancy row memory, neighbor capture, face exposure and vertex packing.
// ---------------------------------------------------------------------------
module vfc_datapath #(
	parameter int unsigned CHUNK_WIDTH  = vfc_pkg::CHUNK_WIDTH_DEF,
	parameter int unsigned CHUNK_HEIGHT = vfc_pkg::CHUNK_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vfc_pkg::in_item_t item_data,
	input  vfc_pkg::dp_cmd_t  cmd,
	output vfc_pkg::dp_stat_t stat,
	vfc_stream_if.source      vertex
);
	import vfc_pkg::*;

	localparam int unsigned DEPTH = CHUNK_WIDTH * CHUNK_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned ZW    = $clog2(CHUNK_WIDTH);
	localparam logic [3:0]  WMAX  = 4'(CHUNK_WIDTH - 1);
	localparam logic [6:0]  HMAX  = 7'(CHUNK_HEIGHT - 1);
	localparam logic [4:0]  WLIM  = 5'(CHUNK_WIDTH);
	localparam logic [7:0]  HLIM  = 8'(CHUNK_HEIGHT);

	// one row per (y, x) column, one bit per z
	logic [CHUNK_WIDTH-1:0] mem [DEPTH];
	logic [CHUNK_WIDTH-1:0] rdata_q;
	logic [CHUNK_WIDTH-1:0] wdata;

	in_item_t item_q;
	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] own_addr;
	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic [4:0]    nx;
	logic [7:0]    ny;
	logic          rd_ok;
	logic          own_ok;

	logic    rd_vld_s1;
	rd_sel_t rd_sel_s1;
	logic    rng_s1;

	logic [5:0] solid_q;
	logic [5:0] show;

	logic [4:0] zc;
	logic [4:0] zp;
	logic [4:0] zm;
	logic       zc_ok;
	logic       zp_ok;
	logic       zm_ok;

	logic [2:0] offs;
	logic [4:0] vx;
	logic [6:0] vy;
	logic [4:0] vz;

	out_item_t out_q;
	logic      out_vld_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_data;
		end
	end

	always_comb begin
		nx = {1'b0, item_q.pos_x};
		ny = {1'b0, item_q.pos_y};
		case (cmd.rd_sel)
			RD_OWN:   ;
			RD_UP:    ny = ny + 8'd1;
			RD_DOWN:  ny = ny - 8'd1;
			RD_LEFT:  nx = nx - 5'd1;
			RD_RIGHT: nx = nx + 5'd1;
			default:  ;
		endcase
	end

	assign rd_ok    = (nx < WLIM) && (ny < HLIM);
	assign rd_addr  = AW'(AW'(ny) * AW'(CHUNK_WIDTH) + AW'(nx));
	assign own_addr = AW'(AW'(item_q.pos_y) * AW'(CHUNK_WIDTH) + AW'(item_q.pos_x));
	assign own_ok   = ({1'b0, item_q.pos_x} < WLIM) && ({1'b0, item_q.pos_y} < HLIM) && zc_ok;

	assign zc    = {1'b0, item_q.pos_z};
	assign zp    = zc + 5'd1;
	assign zm    = zc - 5'd1;
	assign zc_ok = zc < WLIM;
	assign zp_ok = zp < WLIM;
	assign zm_ok = (zc != 5'd0) && (zm < WLIM);

	always_comb begin
		wdata = rdata_q;
		wdata[zc[ZW-1:0]] = item_q.occupied_value;
	end

	assign wr_en   = cmd.clr_en || (cmd.mem_wr && own_ok);
	assign wr_addr = cmd.clr_en ? clr_addr_q : own_addr;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.clr_en ? '0 : wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (cmd.clr_en) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_sel_s1 <= cmd.rd_sel;
		rng_s1    <= rd_ok;
	end

	// pick out the neighbor bits of the row that just came back
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			case (rd_sel_s1)
				RD_OWN: begin
					solid_q[FACE_FRONT] <= rng_s1 && zp_ok && rdata_q[zp[ZW-1:0]];
					solid_q[FACE_BACK]  <= rng_s1 && zm_ok && rdata_q[zm[ZW-1:0]];
				end
				RD_UP:    solid_q[FACE_TOP]    <= rng_s1 && zc_ok && rdata_q[zc[ZW-1:0]];
				RD_DOWN:  solid_q[FACE_BOTTOM] <= rng_s1 && zc_ok && rdata_q[zc[ZW-1:0]];
				RD_LEFT:  solid_q[FACE_LEFT]   <= rng_s1 && zc_ok && rdata_q[zc[ZW-1:0]];
				RD_RIGHT: solid_q[FACE_RIGHT]  <= rng_s1 && zc_ok && rdata_q[zc[ZW-1:0]];
				default:  ;
			endcase
		end
	end

	always_comb begin
		show[FACE_TOP]    = (item_q.pos_y == HMAX) || !solid_q[FACE_TOP];
		show[FACE_BOTTOM] = (item_q.pos_y == 7'd0) || !solid_q[FACE_BOTTOM];
		show[FACE_LEFT]   = (item_q.pos_x == 4'd0) ? !item_q.neighbor_left_solid
			: !solid_q[FACE_LEFT];
		show[FACE_RIGHT]  = (item_q.pos_x == WMAX) ? !item_q.neighbor_right_solid
			: !solid_q[FACE_RIGHT];
		show[FACE_FRONT]  = (item_q.pos_z == WMAX) ? !item_q.neighbor_front_solid
			: !solid_q[FACE_FRONT];
		show[FACE_BACK]   = (item_q.pos_z == 4'd0) ? !item_q.neighbor_back_solid
			: !solid_q[FACE_BACK];
	end

	assign offs = corner_offset(cmd.face, cmd.corner);
	assign vx   = {1'b0, item_q.pos_x} + {4'd0, offs[2]};
	assign vy   = item_q.pos_y + {6'd0, offs[1]};
	assign vz   = {1'b0, item_q.pos_z} + {4'd0, offs[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (vertex.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.vertex_word <= {normal_code(cmd.face), item_q.cube_type, vz, vy, vx};
			out_q.last_vertex <= cmd.last;
		end
	end

	assign vertex.valid = out_vld_q;
	assign vertex.data  = out_q;

	assign stat.opcode    = item_q.opcode;
	assign stat.show      = show;
	assign stat.out_stall = out_vld_q && !vertex.ready;
	assign stat.clr_done  = clr_addr_q == AW'(DEPTH - 1);

endmodule

@@ rtl/core/vfc_ctrl.sv @@
// ---------------------------------------------------------------------------
// vfc_ctrl
// Sequencer: clearing pass, neighbor row reads, write-back and face emission.
// ---------------------------------------------------------------------------
module vfc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output vfc_pkg::dp_cmd_t  cmd,
	input  vfc_pkg::dp_stat_t stat
);
	import vfc_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_WAIT,
		ST_START,
		ST_EMIT
	} state_t;

	state_t     state_q;
	rd_sel_t    rd_sel_q;
	face_t      face_q;
	logic [2:0] corner_q;

	face_t first_face;
	face_t next_face;
	logic  more;

	// lowest shown face overall, and lowest shown face above the current one
	always_comb begin
		first_face = FACE_TOP;
		next_face  = FACE_TOP;
		more       = 1'b0;
		for (int i = 5; i >= 0; i--) begin
			if (stat.show[i]) begin
				first_face = face_t'(3'(i));
				if (3'(i) > face_q) begin
					next_face = face_t'(3'(i));
					more      = 1'b1;
				end
			end
		end
	end

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.rd_en   = state_q == ST_READ;
		cmd.rd_sel  = rd_sel_q;
		cmd.mem_wr  = state_q == ST_WRITE;
		cmd.clr_en  = state_q == ST_CLEAR;
		cmd.emit    = (state_q == ST_EMIT) && !stat.out_stall;
		cmd.face    = face_q;
		cmd.corner  = corner_q;
		cmd.last    = (corner_q == CORNER_LAST) && !more;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			rd_sel_q <= RD_OWN;
			face_q   <= FACE_TOP;
			corner_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (stat.clr_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q  <= ST_READ;
						rd_sel_q <= RD_OWN;
					end
				end
				ST_READ: begin
					case (rd_sel_q)
						RD_OWN: begin
							if (stat.opcode == OP_WRITE) begin
								state_q <= ST_WRITE;
							end else begin
								rd_sel_q <= RD_UP;
							end
						end
						RD_UP:    rd_sel_q <= RD_DOWN;
						RD_DOWN:  rd_sel_q <= RD_LEFT;
						RD_LEFT:  rd_sel_q <= RD_RIGHT;
						default:  state_q  <= ST_WAIT;
					endcase
				end
				ST_WRITE: state_q <= ST_IDLE;
				ST_WAIT:  state_q <= ST_START;
				ST_START: begin
					if (stat.show == 6'd0) begin
						state_q <= ST_IDLE;
					end else begin
						face_q   <= first_face;
						corner_q <= '0;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold while the output register is still full
					if (!stat.out_stall) begin
						if (corner_q == CORNER_LAST) begin
							corner_q <= '0;
							if (more) begin
								face_q <= next_face;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							corner_q <= corner_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/voxel_face_cull_mesher.sv @@
// ---------------------------------------------------------------------------
// voxel_face_cull_mesher: an occupancy write reads its own row and writes it back
// before ready rises again. A mesh item does row reads (one memory port, five rows),
// emits up to 36 vertices, one per cycle unless the output stalls, then goes ready.
// After reset a clearing pass zeroes one row a cycle until all rows are clear.
// ---------------------------------------------------------------------------
module voxel_face_cull_mesher #(
	parameter int unsigned CHUNK_WIDTH  = vfc_pkg::CHUNK_WIDTH_DEF,
	parameter int unsigned CHUNK_HEIGHT = vfc_pkg::CHUNK_HEIGHT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	vfc_stream_if.sink   item,
	vfc_stream_if.source vertex
);
	import vfc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	assign item.ready = in_ready;

	vfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	vfc_datapath #(
		.CHUNK_WIDTH  (CHUNK_WIDTH),
		.CHUNK_HEIGHT (CHUNK_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_data (item.data),
		.cmd       (cmd),
		.stat      (stat),
		.vertex    (vertex)
	);

endmodule
